/* rtl/assert_macros.svh */
// shared assertion macros, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/lpee_pkg.sv */
package lpee_pkg;

  localparam int SensorCount = 12;
  localparam int ThreshBits  = 12;
  localparam int SlotBits    = 16;
  localparam int SlotCount   = 11;
  localparam int WeightBits  = SlotBits * SlotCount;
  localparam int ErrBits     = SlotBits + 1;
  localparam int OutBits     = 16;
  localparam int TimeBits    = 32;
  localparam int DelayBits   = 16;
  localparam int MaxErrBits  = 15;
  localparam int CfgDataBits = 64;
  localparam int CfgIdxBits  = 3;
  localparam int RuleCount   = 23;

  localparam logic [ThreshBits-1:0] ThreshReset = 12'd3000;
  localparam logic [DelayBits-1:0]  DelayReset  = 16'd100;
  localparam logic [3:0]            ZeroSlot    = 4'd11;

  // output clamp, symmetric around zero
  localparam logic signed [ErrBits-1:0] OutLimit = 17'sd32767;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWeightsLow  = 3'd0,
    RegWeightsMid  = 3'd1,
    RegWeightsHigh = 3'd2,
    RegMaxError    = 3'd3,
    RegThreshold   = 3'd4,
    RegClearDelay  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SideClear = 2'd0,
    SideLeft  = 2'd1,
    SideRight = 2'd2
  } side_e;

  // sensor masks, S1 (L_max) in bit 0
  localparam logic [SensorCount-1:0] MLmax = 12'h001;
  localparam logic [SensorCount-1:0] ML4   = 12'h002;
  localparam logic [SensorCount-1:0] ML3   = 12'h004;
  localparam logic [SensorCount-1:0] ML2   = 12'h008;
  localparam logic [SensorCount-1:0] ML1   = 12'h010;
  localparam logic [SensorCount-1:0] MMid1 = 12'h020;
  localparam logic [SensorCount-1:0] MMid2 = 12'h040;
  localparam logic [SensorCount-1:0] MR1   = 12'h080;
  localparam logic [SensorCount-1:0] MR2   = 12'h100;
  localparam logic [SensorCount-1:0] MR3   = 12'h200;
  localparam logic [SensorCount-1:0] MR4   = 12'h400;
  localparam logic [SensorCount-1:0] MRmax = 12'h800;

  typedef struct packed {
    logic [SensorCount-1:0] need;
    logic [3:0]             slot;
    logic                   neg;
  } rule_t;

  // first match wins, entry 0 has top priority
  localparam rule_t Rules [RuleCount] = '{
    '{need: MMid1 | MMid2 | ML1, slot: 4'd0,   neg: 1'b0},
    '{need: MMid1 | MMid2 | MR1, slot: 4'd0,   neg: 1'b1},
    '{need: MMid1 | MMid2,       slot: ZeroSlot, neg: 1'b0},
    '{need: MR2 | MR1 | MMid2,   slot: 4'd2,   neg: 1'b1},
    '{need: ML2 | ML1 | MMid1,   slot: 4'd2,   neg: 1'b0},
    '{need: MR1 | MMid2,         slot: 4'd1,   neg: 1'b1},
    '{need: ML1 | MMid1,         slot: 4'd1,   neg: 1'b0},
    '{need: MR1 | MR2 | MR3,     slot: 4'd4,   neg: 1'b1},
    '{need: ML1 | ML2 | ML3,     slot: 4'd4,   neg: 1'b0},
    '{need: MR1 | MR2,           slot: 4'd3,   neg: 1'b1},
    '{need: ML1 | ML2,           slot: 4'd3,   neg: 1'b0},
    '{need: MR2 | MR3 | MR4,     slot: 4'd6,   neg: 1'b1},
    '{need: ML2 | ML3 | ML4,     slot: 4'd6,   neg: 1'b0},
    '{need: MR2 | MR3,           slot: 4'd5,   neg: 1'b1},
    '{need: ML2 | ML3,           slot: 4'd5,   neg: 1'b0},
    '{need: MR3 | MR4 | MRmax,   slot: 4'd8,   neg: 1'b1},
    '{need: ML3 | ML4 | MLmax,   slot: 4'd8,   neg: 1'b0},
    '{need: MR3 | MR4,           slot: 4'd7,   neg: 1'b1},
    '{need: ML3 | ML4,           slot: 4'd7,   neg: 1'b0},
    '{need: MR4 | MRmax,         slot: 4'd9,   neg: 1'b1},
    '{need: ML4 | MLmax,         slot: 4'd9,   neg: 1'b0},
    '{need: MRmax,               slot: 4'd10,  neg: 1'b1},
    '{need: MLmax,               slot: 4'd10,  neg: 1'b0}
  };

  // clamp a 17-bit error into the 16-bit output range
  function automatic logic signed [OutBits-1:0] sat_err(logic signed [ErrBits-1:0] v);
    logic signed [ErrBits-1:0] c;
    if (v > OutLimit) begin
      c = OutLimit;
    end else if (v < -OutLimit) begin
      c = -OutLimit;
    end else begin
      c = v;
    end
    return c[OutBits-1:0];
  endfunction

endpackage

/* rtl/line_position_error_estimator.sv */
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------------
// in        | sink      | in_valid_i / in_stall_o  | left_outer, left_inner, right_inner,
//           |           |                          | right_outer, now_ms
// out       | source    | out_valid_o / out_stall_i| position_error, line_lost, remembered_side
// cfg       | sink      | cfg_we_i (no wait)       | cfg_index_i, cfg_data_i
//
// one beat per cycle sustained while out_stall_i is low, via the input and result registers
// the per-beat path is the threshold compare bank, the rule priority select and the
// side/time update, all between the input register and the result register
// rst_ni is asynchronous active low: clears valids, side, saved time and previous error,
// config goes to weights 0, threshold 3000, clear delay 100 ms
// a stalled result holds the result register; the input register then holds too and
// in_stall_o rises only while both stages are full and the output is stalled
`include "assert_macros.svh"

module line_position_error_estimator #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,

  // config write port
  input  logic                                    cfg_we_i,
  input  logic [lpee_pkg::CfgIdxBits-1:0]         cfg_index_i,
  input  logic [lpee_pkg::CfgDataBits-1:0]        cfg_data_i,

  // input beat
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [3*SAMPLE_BITS-1:0]                left_outer_i,
  input  logic [3*SAMPLE_BITS-1:0]                left_inner_i,
  input  logic [3*SAMPLE_BITS-1:0]                right_inner_i,
  input  logic [3*SAMPLE_BITS-1:0]                right_outer_i,
  input  logic [lpee_pkg::TimeBits-1:0]           now_ms_i,

  // result beat
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [lpee_pkg::OutBits-1:0]     position_error_o,
  output logic                                    line_lost_o,
  output logic [1:0]                              remembered_side_o
);

  localparam int SampleAll = lpee_pkg::SensorCount * SAMPLE_BITS;
  localparam int CmpW      = (SAMPLE_BITS > lpee_pkg::ThreshBits) ? SAMPLE_BITS
                                                                  : lpee_pkg::ThreshBits;

  // ---------------------------------------------------------------- config registers
  logic [63:0]                          weights_low_q;
  logic [63:0]                          weights_mid_q;
  logic [47:0]                          weights_high_q;
  logic [lpee_pkg::MaxErrBits-1:0]      max_error_q;
  logic [lpee_pkg::ThreshBits-1:0]      threshold_q;
  logic [lpee_pkg::DelayBits-1:0]       clear_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_low_q  <= '0;
      weights_mid_q  <= '0;
      weights_high_q <= '0;
      max_error_q    <= '0;
      threshold_q    <= lpee_pkg::ThreshReset;
      clear_delay_q  <= lpee_pkg::DelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lpee_pkg::RegWeightsLow:  weights_low_q  <= cfg_data_i;
        lpee_pkg::RegWeightsMid:  weights_mid_q  <= cfg_data_i;
        lpee_pkg::RegWeightsHigh: weights_high_q <= cfg_data_i[47:0];
        lpee_pkg::RegMaxError:    max_error_q    <= cfg_data_i[lpee_pkg::MaxErrBits-1:0];
        lpee_pkg::RegThreshold:   threshold_q    <= cfg_data_i[lpee_pkg::ThreshBits-1:0];
        lpee_pkg::RegClearDelay:  clear_delay_q  <= cfg_data_i[lpee_pkg::DelayBits-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic in_valid_q;
  logic out_valid_q;
  logic in_fire;
  logic advance;  // input stage moves into the result stage

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_fire || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // ---------------------------------------------------------------- input register
  logic [SampleAll-1:0]          samples_q;
  logic [lpee_pkg::TimeBits-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      // S1 in the low bits, S12 in the high bits
      samples_q <= {right_outer_i, right_inner_i, left_inner_i, left_outer_i};
      now_q     <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------- detection
  logic [lpee_pkg::SensorCount-1:0] det;

  always_comb begin
    for (int k = 0; k < lpee_pkg::SensorCount; k++) begin
      det[k] = CmpW'(samples_q[k*SAMPLE_BITS +: SAMPLE_BITS]) > CmpW'(threshold_q);
    end
  end

  // ---------------------------------------------------------------- rule priority
  logic       hit;
  logic [3:0] hit_slot;
  logic       hit_neg;

  // walk from lowest priority up so the first matching rule wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = lpee_pkg::ZeroSlot;
    hit_neg  = 1'b0;
    for (int r = lpee_pkg::RuleCount - 1; r >= 0; r--) begin
      if ((det & lpee_pkg::Rules[r].need) == lpee_pkg::Rules[r].need) begin
        hit      = 1'b1;
        hit_slot = lpee_pkg::Rules[r].slot;
        hit_neg  = lpee_pkg::Rules[r].neg;
      end
    end
  end

  // weight lookup, the centre-only slot reads as zero
  logic [lpee_pkg::WeightBits-1:0] weight_cat;
  logic [lpee_pkg::SlotBits-1:0]   hit_weight;
  logic [lpee_pkg::SlotBits-1:0]   w5;

  assign weight_cat = {weights_high_q, weights_mid_q, weights_low_q};
  assign w5         = weights_mid_q[31:16];

  always_comb begin
    if (hit_slot < lpee_pkg::ZeroSlot) begin
      hit_weight = weight_cat[{hit_slot, 4'b0000} +: lpee_pkg::SlotBits];
    end else begin
      hit_weight = '0;
    end
  end

  logic signed [lpee_pkg::ErrBits-1:0] err;
  logic signed [lpee_pkg::ErrBits-1:0] w5_s;

  assign w5_s = $signed({1'b0, w5});
  assign err  = hit_neg ? -$signed({1'b0, hit_weight}) : $signed({1'b0, hit_weight});

  // ---------------------------------------------------------------- state update
  logic signed [lpee_pkg::ErrBits-1:0]  prev_err_q, prev_err_d;
  lpee_pkg::side_e                      side_q, side_d;
  logic [lpee_pkg::TimeBits-1:0]        big_time_q, big_time_d;
  logic [lpee_pkg::TimeBits-1:0]        clear_at;
  logic signed [lpee_pkg::OutBits-1:0]  result_err;

  always_comb begin
    prev_err_d = prev_err_q;
    side_d     = side_q;
    big_time_d = big_time_q;
    clear_at   = '0;
    if (!hit) begin
      // line lost: steer toward the remembered side, else repeat the last error
      unique case (side_q)
        lpee_pkg::SideLeft: begin
          big_time_d = now_q;
          result_err = lpee_pkg::sat_err($signed({2'b00, max_error_q}));
        end
        lpee_pkg::SideRight: begin
          big_time_d = now_q;
          result_err = lpee_pkg::sat_err(-$signed({2'b00, max_error_q}));
        end
        default: begin
          result_err = lpee_pkg::sat_err(prev_err_q);
        end
      endcase
    end else begin
      if (err > w5_s) begin
        side_d     = lpee_pkg::SideLeft;
        big_time_d = now_q;
      end else if (err < -w5_s) begin
        side_d     = lpee_pkg::SideRight;
        big_time_d = now_q;
      end
      // wrapping sum, compared as unsigned
      clear_at = big_time_d + lpee_pkg::TimeBits'(clear_delay_q);
      if (clear_at < now_q) begin
        side_d = lpee_pkg::SideClear;
      end
      prev_err_d = err;
      result_err = lpee_pkg::sat_err(err);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      side_q     <= lpee_pkg::SideClear;
      big_time_q <= '0;
    end else if (advance) begin
      prev_err_q <= prev_err_d;
      side_q     <= side_d;
      big_time_q <= big_time_d;
    end
  end

  // ---------------------------------------------------------------- result register
  logic signed [lpee_pkg::OutBits-1:0] out_err_q;
  logic                                out_lost_q;
  logic [1:0]                          out_side_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_err_q  <= result_err;
      out_lost_q <= !hit;
      out_side_q <= side_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign position_error_o  = out_err_q;
  assign line_lost_o       = out_lost_q;
  assign remembered_side_o = out_side_q;

  // ---------------------------------------------------------------- assertions
  logic signed [lpee_pkg::OutBits-1:0] prev_sat;
  assign prev_sat = lpee_pkg::sat_err(prev_err_q);

  // the shown side is always the side the state now holds
  `ASSERT_PROP(side_matches_state, clk_i, rst_ni,
    out_valid_q |-> (out_side_q == side_q), "result side differs from held side")

  // lost with no side remembered repeats the held previous error
  `ASSERT_PROP(lost_repeats_prev, clk_i, rst_ni,
    (out_valid_q && out_lost_q && (out_side_q == lpee_pkg::SideClear)) |->
    (out_err_q == prev_sat), "lost beat did not repeat previous error")

  // a waiting input beat reaches the result stage whenever that stage is free
  `ASSERT_PROP(input_moves_on, clk_i, rst_ni,
    (in_valid_q && !(out_valid_q && out_stall_i)) |=> out_valid_q,
    "input beat not moved into result stage")

endmodule

/* sim/line_position_error_estimator_tb.sv */
`timescale 1ns / 100ps

module line_position_error_estimator_tb;

  localparam int SampleBits = 12;
  localparam int BeatBits   = lpee_pkg::SensorCount * SampleBits;
  localparam int IdleLimit  = 1000;
  localparam int TourLength = 27;

  // one bit per sensor, L_max in bit 0
  localparam logic [11:0] SnsLmax = 12'h001;
  localparam logic [11:0] SnsL4   = 12'h002;
  localparam logic [11:0] SnsL3   = 12'h004;
  localparam logic [11:0] SnsL2   = 12'h008;
  localparam logic [11:0] SnsL1   = 12'h010;
  localparam logic [11:0] SnsMid1 = 12'h020;
  localparam logic [11:0] SnsMid2 = 12'h040;
  localparam logic [11:0] SnsR1   = 12'h080;
  localparam logic [11:0] SnsR2   = 12'h100;
  localparam logic [11:0] SnsR3   = 12'h200;
  localparam logic [11:0] SnsR4   = 12'h400;
  localparam logic [11:0] SnsRmax = 12'h800;

  // weight slot that reads as zero, and the sign of a pattern
  localparam logic [3:0] NoWeightSlot = 4'd11;
  localparam logic       ToLeft       = 1'b0;
  localparam logic       ToRight      = 1'b1;

  // indexes past the last register, the block must ignore them
  localparam logic [lpee_pkg::CfgIdxBits-1:0] SpareIdxLo = 3'd6;
  localparam logic [lpee_pkg::CfgIdxBits-1:0] SpareIdxHi = 3'd7;

  typedef struct packed {
    logic signed [15:0] err;
    logic               lost;
    logic [1:0]         side;
  } error_beat_t;

  // scoreboard: keeps its own copy of the registers and the steering state,
  // predicts one result beat per accepted sensor beat
  class error_scoreboard;
    logic [63:0]        weights_low;
    logic [63:0]        weights_mid;
    logic [47:0]        weights_high;
    logic [14:0]        max_error;
    logic [11:0]        threshold;
    logic [15:0]        clear_delay;
    logic signed [16:0] last_error;
    lpee_pkg::side_e    side;
    logic [31:0]        big_error_ms;
    error_beat_t        expected_errors [$];
    int                 mismatches;
    int                 checked;
    int                 noted;
    int                 lost_count;
    int                 side_count;

    function new();
      weights_low  = '0;
      weights_mid  = '0;
      weights_high = '0;
      max_error    = '0;
      threshold    = 12'd3000;
      clear_delay  = 16'd100;
      last_error   = '0;
      side         = lpee_pkg::SideClear;
      big_error_ms = '0;
      mismatches   = 0;
      checked      = 0;
      noted        = 0;
      lost_count   = 0;
      side_count   = 0;
    endfunction

    function void write_reg(input logic [lpee_pkg::CfgIdxBits-1:0] idx,
                            input logic [63:0] data);
      case (idx)
        lpee_pkg::RegWeightsLow:  weights_low  = data;
        lpee_pkg::RegWeightsMid:  weights_mid  = data;
        lpee_pkg::RegWeightsHigh: weights_high = data[47:0];
        lpee_pkg::RegMaxError:    max_error    = data[14:0];
        lpee_pkg::RegThreshold:   threshold    = data[11:0];
        lpee_pkg::RegClearDelay:  clear_delay  = data[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_errors.size();
    endfunction

    function logic [15:0] slot_weight(input int unsigned slot);
      if (slot < 4) return weights_low[16*slot +: 16];
      if (slot < 8) return weights_mid[16*(slot-4) +: 16];
      if (slot < 11) return weights_high[16*(slot-8) +: 16];
      return '0;
    endfunction

    // {needed sensors, weight slot, sign}, first match wins
    function logic [16:0] steer_rule(input int k);
      case (k)
        0:  return {SnsMid1 | SnsMid2 | SnsL1, 4'd0, ToLeft};
        1:  return {SnsMid1 | SnsMid2 | SnsR1, 4'd0, ToRight};
        2:  return {SnsMid1 | SnsMid2, NoWeightSlot, ToLeft};
        3:  return {SnsR2 | SnsR1 | SnsMid2, 4'd2, ToRight};
        4:  return {SnsL2 | SnsL1 | SnsMid1, 4'd2, ToLeft};
        5:  return {SnsR1 | SnsMid2, 4'd1, ToRight};
        6:  return {SnsL1 | SnsMid1, 4'd1, ToLeft};
        7:  return {SnsR1 | SnsR2 | SnsR3, 4'd4, ToRight};
        8:  return {SnsL1 | SnsL2 | SnsL3, 4'd4, ToLeft};
        9:  return {SnsR1 | SnsR2, 4'd3, ToRight};
        10: return {SnsL1 | SnsL2, 4'd3, ToLeft};
        11: return {SnsR2 | SnsR3 | SnsR4, 4'd6, ToRight};
        12: return {SnsL2 | SnsL3 | SnsL4, 4'd6, ToLeft};
        13: return {SnsR2 | SnsR3, 4'd5, ToRight};
        14: return {SnsL2 | SnsL3, 4'd5, ToLeft};
        15: return {SnsR3 | SnsR4 | SnsRmax, 4'd8, ToRight};
        16: return {SnsL3 | SnsL4 | SnsLmax, 4'd8, ToLeft};
        17: return {SnsR3 | SnsR4, 4'd7, ToRight};
        18: return {SnsL3 | SnsL4, 4'd7, ToLeft};
        19: return {SnsR4 | SnsRmax, 4'd9, ToRight};
        20: return {SnsL4 | SnsLmax, 4'd9, ToLeft};
        21: return {SnsRmax, 4'd10, ToRight};
        22: return {SnsLmax, 4'd10, ToLeft};
        default: return '0;
      endcase
    endfunction

    function logic signed [15:0] clamp(input logic signed [16:0] v);
      if (v > 17'sd32767) return 16'sd32767;
      if (v < -17'sd32767) return -16'sd32767;
      return v[15:0];
    endfunction

    function void note_sensor_beat(input logic [BeatBits-1:0] s, input logic [31:0] now);
      logic [11:0]        seen;
      logic [16:0]        rule;
      logic signed [16:0] err;
      logic signed [16:0] mag;
      logic signed [16:0] w5;
      logic [31:0]        expiry;
      logic               hit;
      error_beat_t        e;
      for (int k = 0; k < lpee_pkg::SensorCount; k++) begin
        seen[k] = s[SampleBits*k +: SampleBits] > threshold;
      end
      hit = 1'b0;
      err = '0;
      for (int k = 0; k < lpee_pkg::RuleCount; k++) begin
        rule = steer_rule(k);
        if (!hit && ((seen & rule[16:5]) == rule[16:5])) begin
          mag = $signed({1'b0, slot_weight(rule[4:1])});
          err = (rule[0] == ToRight) ? -mag : mag;
          hit = 1'b1;
        end
      end
      w5 = $signed({1'b0, slot_weight(5)});
      if (!hit) begin
        // line lost: steer hard toward the held side and refresh its time, else repeat the last error
        if (side == lpee_pkg::SideLeft) begin
          big_error_ms = now;
          e.err = clamp($signed({2'b00, max_error}));
        end else if (side == lpee_pkg::SideRight) begin
          big_error_ms = now;
          e.err = clamp(-$signed({2'b00, max_error}));
        end else begin
          e.err = clamp(last_error);
        end
        e.lost = 1'b1;
      end else begin
        if (err > w5) begin
          side = lpee_pkg::SideLeft;
          big_error_ms = now;
        end else if (err < -w5) begin
          side = lpee_pkg::SideRight;
          big_error_ms = now;
        end
        expiry = big_error_ms + {16'h0000, clear_delay};
        if (expiry < now) side = lpee_pkg::SideClear;
        last_error = err;
        e.err = clamp(err);
        e.lost = 1'b0;
      end
      e.side = side;
      expected_errors.push_back(e);
      noted++;
    endfunction

    task flag(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40) begin
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, checked, got, want);
      end
    endtask

    task check_result(input logic signed [15:0] err, input logic lost,
                      input logic [1:0] sd);
      error_beat_t e;
      checked++;
      if (expected_errors.size() == 0) begin
        flag("result beat with nothing expected", err, 0);
        return;
      end
      e = expected_errors.pop_front();
      if (err !== e.err) flag("position_error", err, e.err);
      if (lost !== e.lost) flag("line_lost", lost, e.lost);
      if (sd !== e.side) flag("remembered_side", sd, e.side);
      if (e.lost) lost_count++;
      if (e.side != lpee_pkg::SideClear) side_count++;
    endtask
  endclass

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_we_i      = 1'b0;
  logic [lpee_pkg::CfgIdxBits-1:0]      cfg_index_i   = '0;
  logic [lpee_pkg::CfgDataBits-1:0]     cfg_data_i    = '0;
  logic                                 in_valid_i    = 1'b0;
  logic                                 in_stall_o;
  logic [3*SampleBits-1:0]              left_outer_i  = '0;
  logic [3*SampleBits-1:0]              left_inner_i  = '0;
  logic [3*SampleBits-1:0]              right_inner_i = '0;
  logic [3*SampleBits-1:0]              right_outer_i = '0;
  logic [lpee_pkg::TimeBits-1:0]        now_ms_i      = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i   = 1'b0;
  logic signed [lpee_pkg::OutBits-1:0]  position_error_o;
  logic                                 line_lost_o;
  logic [1:0]                           remembered_side_o;

  error_scoreboard tracker;
  logic [31:0]     ms_clock        = '0;
  int              sent            = 0;
  int              settings_loaded = 0;
  int unsigned     quiet_cycles    = 0;

  line_position_error_estimator #(
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .left_outer_i     (left_outer_i),
    .left_inner_i     (left_inner_i),
    .right_inner_i    (right_inner_i),
    .right_outer_i    (right_outer_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_error_o (position_error_o),
    .line_lost_o      (line_lost_o),
    .remembered_side_o(remembered_side_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: too many cycles without any beat moving ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // build the 144 sample bits from a detection mask; at_edge puts every sample
  // exactly on the threshold or one above it
  function automatic logic [BeatBits-1:0] samples_from_mask(input logic [11:0] mask,
                                                            input logic at_edge);
    logic [BeatBits-1:0] s;
    logic [11:0]         thr;
    thr = tracker.threshold;
    for (int k = 0; k < lpee_pkg::SensorCount; k++) begin
      if (!mask[k]) begin
        s[SampleBits*k +: SampleBits] = at_edge ? thr : 12'($urandom_range(0, thr));
      end else if (at_edge || thr == 12'hFFF) begin
        s[SampleBits*k +: SampleBits] = thr + 12'd1;
      end else begin
        s[SampleBits*k +: SampleBits] = 12'($urandom_range(thr + 1, 4095));
      end
    end
    return s;
  endfunction

  // directed walk through the pattern table, the lost line and the side memory
  function automatic logic [11:0] tour_mask(input int i);
    case (i)
      0:  return '0;
      1:  return 12'hFFF;
      2:  return '0;
      3:  return 12'hFFF;
      4:  return SnsMid1 | SnsMid2;
      5:  return SnsMid1 | SnsMid2 | SnsR1;
      6:  return SnsMid2 | SnsR1 | SnsR2;
      7:  return SnsL2 | SnsL1 | SnsMid1;
      8:  return SnsMid2 | SnsR1;
      9:  return SnsL1 | SnsMid1;
      10: return SnsR1 | SnsR2 | SnsR3;
      11: return SnsL1 | SnsL2 | SnsL3;
      12: return SnsR1 | SnsR2;
      13: return SnsL1 | SnsL2;
      14: return SnsR2 | SnsR3 | SnsR4;
      15: return '0;
      16: return SnsL2 | SnsL3 | SnsL4;
      17: return SnsL2 | SnsL3;
      18: return SnsR3 | SnsR4 | SnsRmax;
      19: return SnsL3 | SnsL4 | SnsLmax;
      20: return SnsR3 | SnsR4;
      21: return SnsL3 | SnsL4;
      22: return SnsR4 | SnsRmax;
      23: return SnsL4 | SnsLmax;
      24: return SnsRmax;
      25: return SnsLmax;
      26: return SnsMid1 | SnsMid2;
      default: return '0;
    endcase
  endfunction

  // mostly a small step forward, now and then a jump anywhere
  function automatic logic [31:0] tick_ms();
    if ($urandom_range(0, 19) == 0) begin
      ms_clock = $urandom;
    end else begin
      ms_clock = ms_clock + $urandom_range(0, 40);
    end
    return ms_clock;
  endfunction

  // mostly a line under one to three adjacent sensors, then lost line,
  // scattered detections and raw noise
  function automatic logic [BeatBits-1:0] pick_beat();
    int          kind;
    int          span;
    int          pos;
    logic [11:0] mask;
    logic [159:0] raw;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      if (kind < 55) begin
        span = $urandom_range(1, 3);
        pos  = $urandom_range(0, lpee_pkg::SensorCount - span);
        mask = ((12'd1 << span) - 12'd1) << pos;
      end else if (kind < 72) begin
        mask = '0;
      end else begin
        mask = 12'($urandom_range(0, 4095));
      end
      return samples_from_mask(mask, $urandom_range(0, 9) == 0);
    end
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[BeatBits-1:0];
  endfunction

  // offer one sensor beat and hold it until accepted
  task automatic send_beat(input logic [BeatBits-1:0] s, input logic [31:0] now);
    int gap;
    // every fourth stretch of 40 beats goes back to back
    gap = (((sent / 40) % 4) == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_outer_i  <= s[35:0];
    left_inner_i  <= s[71:36];
    right_inner_i <= s[107:72];
    right_outer_i <= s[143:108];
    now_ms_i      <= now;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_sensor_beat(s, now);
    sent++;
  endtask

  // stop offering and let every expected result beat drain out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [lpee_pkg::CfgIdxBits-1:0] idx,
                         input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // full register set, plus two writes to unused indexes
  task automatic load_settings(input logic [63:0] w_low, input logic [63:0] w_mid,
                               input logic [63:0] w_high, input logic [63:0] lost_mag,
                               input logic [63:0] thr, input logic [63:0] delay);
    put_reg(lpee_pkg::RegWeightsLow, w_low);
    put_reg(lpee_pkg::RegWeightsMid, w_mid);
    put_reg(lpee_pkg::RegWeightsHigh, w_high);
    put_reg(lpee_pkg::RegMaxError, lost_mag);
    put_reg(lpee_pkg::RegThreshold, thr);
    put_reg(lpee_pkg::RegClearDelay, delay);
    put_reg(SpareIdxLo, {$urandom, $urandom});
    put_reg(SpareIdxHi, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat(pick_beat(), tick_ms());
    end
    settle();
  endtask

  // result side: random stalls, quiet stretches, and two long hold-offs that
  // fill the pipeline and push back on the sensor side
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (tracker.checked == 400 || tracker.checked == 1100) begin
        gap = 60;
      end else if (((tracker.checked / 48) % 4) == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(position_error_o, line_lost_o, remembered_side_o);
    end
  end

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first two beats run on reset settings, then a graded weight ladder
    // with w5 in the middle so the outer patterns count as big errors
    for (int i = 0; i < TourLength; i++) begin
      if (i == 2) begin
        settle();
        load_settings(64'h0180_0100_0080_0040, 64'h0600_0400_0300_0200,
                      64'hABCD_1000_0C00_0800, 64'h0000_0000_0000_8A00,
                      64'hF000_0000_F000_0BB8, 64'hFFFF_FFFF_FFFF_0064);
      end
      // long jump before the last found pattern lets the held side expire
      ms_clock = ms_clock + ((i == 26) ? 32'd1000 : 32'd5);
      send_beat(samples_from_mask(tour_mask(i), i[0]), ms_clock);
    end
    settle();
    random_run(300);

    // top extremes: every weight and max error at full scale, zero threshold
    load_settings('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_F000, '1);
    random_run(200);

    // bottom extremes: nothing can be detected, zero delay
    load_settings('0, '0, '0, '0, 64'h0000_0000_0000_0FFF, 64'hFFFF_FFFF_FFFF_0000);
    random_run(100);

    // random settings with a clear delay of at most 300 ms, time near the 32-bit wrap
    ms_clock = 32'hFFFF_FF00;
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom},
                  64'($urandom_range(0, 300)));
    random_run(300);

    // weights past the output range with a small w5: saturated big errors
    load_settings({$urandom, $urandom} | {4{16'h8000}},
                  (({$urandom, $urandom} | {4{16'h8000}}) & 64'hFFFF_FFFF_0000_FFFF)
                    | 64'h0000_0000_0100_0000,
                  {$urandom, $urandom} | {4{16'h8000}},
                  {$urandom, $urandom}, 64'd2000, 64'($urandom_range(0, 50)));
    random_run(300);

    // graded ladder again with random threshold and delay
    load_settings(64'h0180_0100_0080_0040, 64'h0600_0400_0300_0200,
                  64'h0000_1000_0C00_0800, {$urandom, $urandom},
                  64'($urandom_range(500, 3500)), 64'($urandom_range(0, 300)));
    random_run(300);

    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.flag("result beats never delivered", tracker.pending(), 0);
    end
    $display("sent %0d sensor beats under %0d register settings",
             tracker.noted, settings_loaded);
    $display("checked %0d result beats: %0d with the line lost, %0d with a side held",
             tracker.checked, tracker.lost_count, tracker.side_count);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
